### rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types and codes shared by the thread slot scheduler with per-slot mailboxes.
// ----------------------------------------------------------------------------
package tss_pkg;

  typedef enum logic [2:0] {
    OP_PROCEED = 3'd0,
    OP_CREATE  = 3'd1,
    OP_EXIT    = 3'd2,
    OP_SEND    = 3'd3,
    OP_RECV    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_NO_READY = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  localparam int unsigned TargetW = 3;
  localparam int unsigned MsgW    = 32;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [TargetW-1:0]     target_thread;
    logic signed [MsgW-1:0] message;
  } tss_req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [TargetW-1:0]     thread_id;
    logic signed [MsgW-1:0] message_out;
    logic                   target_ready;
    logic                   target_inbox_empty;
  } tss_rsp_t;

endpackage

### rtl/thread_slot_scheduler_mailbox.sv
// ----------------------------------------------------------------------------
// thread_slot_scheduler_mailbox
// Round-robin thread slot scheduler with one FIFO inbox per slot.
// Latency: the result strobes in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, the inbox RAM read is registered.
// Reset: slot 0 ready and current, every inbox empty; inbox RAM is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module thread_slot_scheduler_mailbox
  import tss_pkg::*;
#(
  parameter int unsigned THREAD_SLOTS = 8,
  parameter int unsigned INBOX_DEPTH  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tss_req_t item_i,
  output logic     done_o,
  output tss_rsp_t result_o
);

  localparam int unsigned SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned PW = (INBOX_DEPTH > 1) ? $clog2(INBOX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(INBOX_DEPTH + 1);
  localparam int unsigned AW = SW + PW;
  localparam int unsigned MemDepth = THREAD_SLOTS * (2 ** PW);
  localparam logic [SW+TargetW-1:0] SlotsC  = (SW + TargetW)'(THREAD_SLOTS);
  localparam logic [CW-1:0]         DepthC  = CW'(INBOX_DEPTH);
  localparam logic [PW-1:0]         PtrLast = PW'(INBOX_DEPTH - 1);

  function automatic logic [SW-1:0] low_index(logic [THREAD_SLOTS-1:0] v);
    logic [THREAD_SLOTS-1:0] one;
    logic [SW-1:0]           idx;
    one = v & (~v + THREAD_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (one[i]) idx = idx | SW'(i);
    end
    return idx;
  endfunction

  // scheduler state
  logic [THREAD_SLOTS-1:0] ready_q, ready_d;
  logic [SW-1:0]           cur_q, cur_d;
  logic [PW-1:0]           head_q [THREAD_SLOTS];
  logic [PW-1:0]           tail_q [THREAD_SLOTS];
  logic [CW-1:0]           count_q [THREAD_SLOTS];

  // result stage
  logic                    done_q;
  logic [2:0]              status_q, status_d;
  logic [TargetW-1:0]      thread_q;
  logic                    tready_q, tready_d;
  logic                    tempty_q, tempty_d;
  logic                    rx_q, rx_d;
  logic [MsgW-1:0]         rdata_q;

  logic [MsgW-1:0]         mem [MemDepth];

  logic                    accept;
  logic [SW+TargetW-1:0]   tgt_ext;
  logic [SW+TargetW-1:0]   cur_ext;
  logic [SW-1:0]           tidx;
  logic                    tgt_ok;
  logic [THREAD_SLOTS-1:0] rr_base;
  logic [THREAD_SLOTS-1:0] above;
  logic [THREAD_SLOTS-1:0] hi;
  logic [SW-1:0]           rr_pick;
  logic [PW-1:0]           t_head, t_tail;
  logic [CW-1:0]           t_count, cnt_new;
  logic                    wr_en, rd_en;
  logic [AW-1:0]           waddr, raddr;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign tgt_ext = {{SW{1'b0}}, item_i.target_thread};
  assign tidx    = tgt_ext[SW-1:0];
  assign tgt_ok  = tgt_ext < SlotsC;

  assign t_head  = head_q[tidx];
  assign t_tail  = tail_q[tidx];
  assign t_count = count_q[tidx];

  // exit drops the current slot before the round-robin search
  always_comb begin
    rr_base = ready_q;
    if (item_i.opcode == OP_EXIT) rr_base[cur_q] = 1'b0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      above[i] = SW'(i) > cur_q;
    end
    hi      = rr_base & above;
    rr_pick = (|hi) ? low_index(hi) : low_index(rr_base);
  end

  always_comb begin
    ready_d  = ready_q;
    cur_d    = cur_q;
    status_d = ST_OK;
    cnt_new  = t_count;
    rx_d     = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    waddr    = {tidx, t_tail};
    raddr    = {tidx, t_head};
    case (item_i.opcode)
      OP_PROCEED, OP_EXIT: begin
        ready_d = rr_base;
        if (|rr_base) cur_d = rr_pick;
        else status_d = ST_NO_READY;
      end
      OP_CREATE: begin
        if (&ready_q) begin
          status_d = ST_NO_FREE;
        end else begin
          cur_d          = low_index(~ready_q);
          ready_d[cur_d] = 1'b1;
        end
      end
      OP_SEND: begin
        if (!tgt_ok || t_count == DepthC) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_new = t_count + CW'(1);
        end
      end
      OP_RECV: begin
        if (!tgt_ok || t_count == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rx_d    = 1'b1;
          cnt_new = t_count - CW'(1);
        end
      end
      default: ;
    endcase
    tready_d = tgt_ok & ready_d[tidx];
    tempty_d = !tgt_ok || cnt_new == '0;
  end

  assign cur_ext = {{TargetW{1'b0}}, cur_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= THREAD_SLOTS'(1);
      cur_q   <= '0;
      done_q  <= 1'b0;
      rx_q    <= 1'b0;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      done_q <= accept;
      if (accept) begin
        ready_q <= ready_d;
        cur_q   <= cur_d;
        rx_q    <= rx_d;
        count_q[tidx] <= cnt_new;
        if (wr_en) tail_q[tidx] <= (t_tail == PtrLast) ? '0 : t_tail + PW'(1);
        if (rd_en) head_q[tidx] <= (t_head == PtrLast) ? '0 : t_head + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      thread_q <= cur_ext[TargetW-1:0];
      tready_q <= tready_d;
      tempty_q <= tempty_d;
    end
  end

  // inbox RAM: at most one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) mem[waddr] <= item_i.message;
    if (accept && rd_en) rdata_q <= mem[raddr];
  end

  assign done_o                      = done_q;
  assign result_o.status             = status_q;
  assign result_o.thread_id          = thread_q;
  assign result_o.message_out        = rx_q ? rdata_q : '0;
  assign result_o.target_ready       = tready_q;
  assign result_o.target_inbox_empty = tempty_q;

endmodule
